>>> src/rlt_pkg.sv
// shared types and constants for the request latency tracker
package rlt_pkg;

  localparam int TableDepth = 256;
  localparam int SlotW = $clog2(TableDepth);

  localparam logic [1:0] KIND_ENQ = 2'd0;
  localparam logic [1:0] KIND_DEQ = 2'd1;
  localparam logic [1:0] KIND_CMP = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [63:0] request_tag;
    logic [15:0] request_opcode;
    logic [31:0] request_length;
    logic signed [31:0] reply_error;
    logic [63:0] now_time;
  } event_t;

  typedef struct packed {
    logic [63:0] done_tag;
    logic [15:0] done_opcode;
    logic [31:0] done_length;
    logic signed [31:0] done_error;
    logic [63:0] enqueue_time;
    logic [63:0] dequeue_time;
    logic [63:0] completion_time;
    logic [63:0] queue_wait;
    logic [63:0] service_time;
    logic [63:0] sequence_number;
  } record_t;

  // one table entry, tag kept in the same word
  typedef struct packed {
    logic [63:0] tag;
    logic [15:0] opcode;
    logic [31:0] length;
    logic [63:0] enq;
    logic [63:0] deq;
    logic [63:0] wait_t;
    logic [63:0] seq;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

>>> src/rlt_if.sv
// valid/ready channel carrying one payload
interface rlt_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/rlt_ram.sv
// generic single port ram with registered read
module rlt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> src/request_latency_tracker.sv
// top level of the request latency tracker
//
// Events arrive on evt (valid/ready); completion records leave on rec.
// Each event scans the table: one entry is read per cycle from a single
// port ram while a per-slot valid vector in flops marks live entries.
// The scan stops at the matching tag; an enqueue of a new tag takes the
// lowest free slot, found from the valid vector. Zero tags and unused
// kinds are dropped at once. Any other event scans until the matching tag
// is hit; the scan always runs to the last slot on a miss.
// A completion of a known tag gives one record, held in an output register
// until the receiver takes it; a new event is accepted meanwhile, and the
// block only waits for the record to leave before it would write another.
// Reset clears the valid vector and the sequence counter;
// no clearing pass is needed.
module request_latency_tracker (
  input logic clk,
  input logic rst,
  rlt_if.sink evt,
  rlt_if.source rec
);
  import rlt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CHK = 3'd2;
  localparam logic [2:0] S_WR = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state;
  event_t ev;
  logic [SlotW:0] idx;
  logic [SlotW-1:0] slot;
  logic [TableDepth-1:0] tag_valid;
  logic [63:0] seq_cnt;
  entry_t rd, wr_entry;
  logic we;
  logic [SlotW-1:0] addr;
  logic out_valid;
  record_t out_rec;
  logic hit;
  logic [SlotW-1:0] free_idx;
  logic free_any;
  logic last;

  rlt_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wr_entry), .rdata(rd)
  );

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!tag_valid[i]) begin
        free_idx = SlotW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign hit = tag_valid[slot] && (rd.tag == ev.request_tag);
  assign last = (slot == SlotW'(TableDepth - 1));
  assign evt.ready = (state == S_IDLE);
  assign rec.valid = out_valid;
  assign rec.data = out_rec;

  always_comb begin
    wr_entry = rd;
    we = 1'b0;
    addr = idx[SlotW-1:0];
    if ((state == S_CHK && hit) || state == S_OUT) addr = slot;
    if (state == S_WR) begin
      addr = slot;
      we = 1'b1;
      if (ev.event_kind == KIND_ENQ) begin
        wr_entry.tag = ev.request_tag;
        wr_entry.opcode = ev.request_opcode;
        wr_entry.length = ev.request_length;
        wr_entry.enq = ev.now_time;
        wr_entry.deq = '0;
        wr_entry.wait_t = '0;
        wr_entry.seq = seq_cnt;
      end else begin
        wr_entry.deq = ev.now_time;
        wr_entry.wait_t = (rd.enq != 0) ? ev.now_time - rd.enq : rd.wait_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tag_valid <= '0;
      seq_cnt <= '0;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (rec.valid && rec.ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (evt.valid) begin
            ev <= evt.data;
            idx <= '0;
            if (evt.data.request_tag != 0 && evt.data.event_kind != KIND_UNUSED) begin
              state <= S_READ;
              if (evt.data.event_kind == KIND_ENQ) seq_cnt <= seq_cnt + 64'd1;
            end
          end
        end
        S_READ: begin
          slot <= idx[SlotW-1:0];
          idx <= idx + 1'b1;
          state <= S_CHK;
        end
        S_CHK: begin
          if (hit) begin
            if (ev.event_kind == KIND_ENQ) state <= S_WR;
            else if (ev.event_kind == KIND_DEQ)
              state <= (rd.deq == 0) ? S_WR : S_IDLE;
            else state <= S_OUT;
          end else if (last) begin
            if (ev.event_kind == KIND_ENQ && free_any) begin
              slot <= free_idx;
              state <= S_WR;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            slot <= idx[SlotW-1:0];
            idx <= idx + 1'b1;
          end
        end
        S_WR: begin
          if (ev.event_kind == KIND_ENQ) tag_valid[slot] <= 1'b1;
          state <= S_IDLE;
        end
        S_OUT: begin
          if (!out_valid || rec.ready) begin
            out_valid <= 1'b1;
            out_rec.done_tag <= rd.tag;
            out_rec.done_opcode <= rd.opcode;
            out_rec.done_length <= rd.length;
            out_rec.done_error <= ev.reply_error;
            out_rec.enqueue_time <= rd.enq;
            out_rec.dequeue_time <= rd.deq;
            out_rec.completion_time <= ev.now_time;
            out_rec.queue_wait <= rd.wait_t;
            out_rec.service_time <= (rd.deq != 0) ? ev.now_time - rd.deq : 64'd0;
            out_rec.sequence_number <= rd.seq;
            tag_valid[slot] <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // in S_CHK the address held by idx is one past slot, so the ram keeps
  // showing slot's data only until the next read; the output stage reads
  // rd in S_OUT, so hold the address there
  a_out_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> tag_valid[slot]) else $error("completion on free slot");
  a_rec_hold: assert property (@(posedge clk) disable iff (rst)
    rec.valid && !rec.ready |=> rec.valid) else $error("record dropped");
  a_wr_state: assert property (@(posedge clk) disable iff (rst)
    we |-> state == S_WR) else $error("stray write");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    evt.valid && evt.ready && evt.data.request_tag != 0 &&
    evt.data.event_kind == KIND_ENQ |=> seq_cnt == $past(seq_cnt) + 64'd1)
    else $error("sequence not advanced");
endmodule
